[sv/dv_dif_block_order_checker_macros.svh]
// Assertion macros for the DV DIF block order checker.
// Depends on nothing; included by the top-level module, which carries the assertions.
`ifndef DV_DIF_BLOCK_ORDER_CHECKER_MACROS_SVH
`define DV_DIF_BLOCK_ORDER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDBOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DDBOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/ddboc_pkg.sv]
// Package for the DV DIF block order checker: item types, state type,
// section codes and order constants. Depends on nothing.
`default_nettype none

package ddboc_pkg;

    // Section type codes.
    localparam logic [2:0] SEC_HEADER  = 3'd0;
    localparam logic [2:0] SEC_SUBCODE = 3'd1;
    localparam logic [2:0] SEC_VAUX    = 3'd2;
    localparam logic [2:0] SEC_AUDIO   = 3'd3;
    localparam logic [2:0] SEC_VIDEO   = 3'd4;

    // Last sequence number of each line system.
    localparam logic [3:0] SEQ_LAST_525 = 4'd9;
    localparam logic [3:0] SEQ_LAST_625 = 4'd11;

    // Blocks per section: the expected block number that wraps back to block 0.
    localparam logic [7:0] WRAP_SUBCODE = 8'd2;
    localparam logic [7:0] WRAP_VAUX    = 8'd3;
    localparam logic [7:0] WRAP_AUDIO   = 8'd9;
    localparam logic [7:0] WRAP_VIDEO   = 8'd135;

    localparam logic [7:0] HEADERS_RESET = 8'd14;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    typedef struct packed {
        logic [2:0] section_type;
        logic [3:0] sequence_number;
        logic [7:0] block_number;
        logic       system_625;
    } t_in_item;

    typedef struct packed {
        logic sequence_error;
        logic block_error;
        logic checking_done;
    } t_out_item;

    // Order tracking state carried between items.
    typedef struct packed {
        logic [2:0]      last_section;
        logic [7:0][7:0] last_block;
        logic [3:0]      last_sequence;
        logic            system_known;
        logic            system_is_625;
        logic [7:0]      header_count;
        logic            accepted;
    } t_state;

    // State after reset: video last seen, each section at its final block.
    function automatic t_state state_reset();
        t_state s;
        s.last_section  = SEC_VIDEO;
        s.last_block    = '0;
        s.last_block[1] = 8'd1;
        s.last_block[2] = 8'd2;
        s.last_block[3] = 8'd8;
        s.last_block[4] = 8'd134;
        s.last_sequence = 4'd0;
        s.system_known  = 1'b0;
        s.system_is_625 = 1'b0;
        s.header_count  = 8'd0;
        s.accepted      = 1'b0;
        return s;
    endfunction

endpackage

`default_nettype wire

[sv/dv_dif_block_order_checker.sv]
// DV DIF block order checker: top level with state and result registers.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries the decoded
//   header of one 80-byte DIF block per item. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns one result item per input item, in order.
//   The result of an item accepted at one edge is valid after that edge.
//   Throughput is one item per cycle while results are taken; the order
//   check is a single pass of logic from state to result register.
//   The input stays ready while the result register is empty or being taken,
//   so a stalled receiver holds the result and stops the input after one item.
//   The configuration write (i_cfg_wr_en / i_cfg_wr_data) sets the number of
//   header blocks after which checking stops; write it only while idle.
//   After checking stops, every item returns checking_done with no errors.
//   Synchronous active-low reset empties the result register, restores the
//   initial order state and sets the header limit to 14.
// Depends on ddboc_pkg, ddboc_check and dv_dif_block_order_checker_macros.svh.
`default_nettype none

module dv_dif_block_order_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire ddboc_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output ddboc_pkg::t_out_item       o_out_data,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [7:0]            i_cfg_wr_data
);
    import ddboc_pkg::*;

    `include "dv_dif_block_order_checker_macros.svh"

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      r_out_valid;
    logic [7:0] r_headers_to_check;
    logic      in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Order check for the item on the input channel.
    ddboc_check u_check (
        .i_state            (r_state),
        .i_item             (i_in_data),
        .i_headers_to_check (r_headers_to_check),
        .o_next_state       (n_state),
        .o_result           (n_out_data)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headers_to_check <= HEADERS_RESET;
        end else if (i_cfg_wr_en) begin
            r_headers_to_check <= i_cfg_wr_data;
        end
    end

    // Order state advances with each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= state_reset();
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Once checking has stopped it never restarts.
    `DDBOC_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_state.accepted, r_state.accepted)
    // Items after the end of checking give a clean done result.
    `DDBOC_ASSERT_NEXT(a_done_result, i_clk, i_rst_n, in_fire && r_state.accepted,
        !o_out_data.sequence_error && !o_out_data.block_error && o_out_data.checking_done)
    // A non-header item leaves the header count alone.
    `DDBOC_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n,
        in_fire && (i_in_data.section_type != SEC_HEADER),
        r_state.header_count == $past(r_state.header_count))
    // The done flag of a result just loaded matches the stored state.
    `DDBOC_ASSERT_NOW(a_done_match, i_clk, i_rst_n, o_out_valid && !$past(in_fire) == 1'b0,
        o_out_data.checking_done == r_state.accepted)

endmodule

`default_nettype wire

[sv/ddboc_check.sv]
// Combinational order check for one DIF block header: result and next state.
// Depends on ddboc_pkg.
`default_nettype none

module ddboc_check (
    input  wire ddboc_pkg::t_state    i_state,
    input  wire ddboc_pkg::t_in_item  i_item,
    input  wire logic [7:0]           i_headers_to_check,
    output ddboc_pkg::t_state         o_next_state,
    output ddboc_pkg::t_out_item      o_result
);
    import ddboc_pkg::*;

    // Rule shared by subcode, VAUX and audio blocks.
    function automatic logic order_bad(
        input logic [7:0] blk,
        input logic [2:0] prev_sec,
        input logic [2:0] first_pred,
        input logic [2:0] later_pred,
        input logic [7:0] expect_blk,
        input logic [7:0] wrap
    );
        logic pred_ok;
        logic num_bad;
        pred_ok = ((blk == 8'd0) && (prev_sec == first_pred)) ||
                  ((blk != 8'd0) && (prev_sec == later_pred));
        num_bad = (expect_blk != blk) && !((expect_blk == wrap) && (blk == 8'd0));
        return !pred_ok || num_bad;
    endfunction

    t_state     nxt;
    logic       seq_err;
    logic       blk_err;
    logic [7:0] expect_blk;
    logic [7:0] count_inc;

    // Sequence check, block check and header bookkeeping.
    always_comb begin
        nxt        = i_state;
        seq_err    = 1'b0;
        blk_err    = 1'b0;
        expect_blk = i_state.last_block[i_item.section_type] + 8'd1;
        count_inc  = (i_state.header_count < COUNT_MAX) ?
                     i_state.header_count + 8'd1 : i_state.header_count;
        if (!i_state.accepted) begin
            // The sequence number may only fall to zero after the system's last one.
            if (i_state.system_known && (i_state.last_sequence != i_item.sequence_number)) begin
                if ((i_item.sequence_number == 4'd0) &&
                    !(!i_state.system_is_625 && (i_state.last_sequence == SEQ_LAST_525)) &&
                    !(i_state.system_is_625 && (i_state.last_sequence == SEQ_LAST_625))) begin
                    seq_err = 1'b1;
                end
                nxt.last_sequence = i_item.sequence_number;
            end

            case (i_item.section_type)
                SEC_HEADER: begin
                    blk_err = (i_state.last_section != SEC_VIDEO) ||
                              (i_item.block_number != 8'd0);
                end
                SEC_SUBCODE: begin
                    blk_err = order_bad(i_item.block_number, i_state.last_section,
                                        SEC_HEADER, SEC_SUBCODE, expect_blk, WRAP_SUBCODE);
                end
                SEC_VAUX: begin
                    blk_err = order_bad(i_item.block_number, i_state.last_section,
                                        SEC_SUBCODE, SEC_VAUX, expect_blk, WRAP_VAUX);
                end
                SEC_AUDIO: begin
                    blk_err = order_bad(i_item.block_number, i_state.last_section,
                                        SEC_VAUX, SEC_VIDEO, expect_blk, WRAP_AUDIO);
                end
                SEC_VIDEO: begin
                    blk_err = !((i_state.last_section == SEC_AUDIO) ||
                                (i_state.last_section == SEC_VIDEO)) ||
                              ((expect_blk != i_item.block_number) &&
                               !((expect_blk == WRAP_VIDEO) && (i_item.block_number == 8'd0)));
                end
                default: begin
                    // Unknown sections are tracked but never checked.
                    blk_err = 1'b0;
                end
            endcase
            nxt.last_section = i_item.section_type;
            nxt.last_block[i_item.section_type] = i_item.block_number;

            // A header fixes the line system and counts towards the end of checking.
            if (i_item.section_type == SEC_HEADER) begin
                nxt.system_is_625 = i_item.system_625;
                nxt.system_known  = 1'b1;
                nxt.last_sequence = i_item.system_625 ? SEQ_LAST_625 : SEQ_LAST_525;
                nxt.header_count  = count_inc;
                if (count_inc >= i_headers_to_check) begin
                    nxt.accepted = 1'b1;
                end
            end
        end
    end

    assign o_next_state            = nxt;
    assign o_result.sequence_error = seq_err;
    assign o_result.block_error    = blk_err;
    assign o_result.checking_done  = nxt.accepted;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the DV DIF block order checker.
// Holds its own order predictor in a scoreboard class and drives both item
// channels and the header limit register; depends on ddboc_pkg and the RTL.
module testbench;
    import ddboc_pkg::*;

    localparam int STALL_LIMIT = 1000;

    // Predicts the order flags of each DIF block header and holds the
    // result items still to come back from the block.
    class dif_order_scoreboard;
        logic [7:0] header_limit;
        logic [2:0] prev_section;
        logic [7:0] prev_block [8];
        logic [3:0] prev_seq;
        logic       sys_known;
        logic       sys_625;
        logic [7:0] header_count;
        logic       done;
        t_out_item  pending [$];
        int         failures;

        function new();
            header_limit = HEADERS_RESET;
            prev_section = SEC_VIDEO;
            prev_block   = '{8'd0, 8'd1, 8'd2, 8'd8, 8'd134, 8'd0, 8'd0, 8'd0};
            prev_seq     = 4'd0;
            sys_known    = 1'b0;
            sys_625      = 1'b0;
            header_count = 8'd0;
            done         = 1'b0;
            failures     = 0;
        endfunction

        // Order rule shared by subcode, VAUX and audio blocks.
        function bit order_broken(logic [7:0] blk, logic [2:0] first_pred,
                                  logic [2:0] later_pred, logic [7:0] want,
                                  logic [7:0] wrap);
            bit pred_ok;
            pred_ok = (blk == 8'd0) ? (prev_section == first_pred)
                                    : (prev_section == later_pred);
            return !pred_ok || (want != blk && !(want == wrap && blk == 8'd0));
        endfunction

        // Work out the result of one accepted item and queue it.
        function void note_block_header(t_in_item it);
            t_out_item  r;
            logic [7:0] want;
            logic [3:0] seq_end;
            r = '0;
            if (done) begin
                r.checking_done = 1'b1;
                pending.push_back(r);
                return;
            end
            // A change of sequence number to 0 must come from the last sequence.
            if (sys_known && it.sequence_number != prev_seq) begin
                seq_end = sys_625 ? SEQ_LAST_625 : SEQ_LAST_525;
                if (it.sequence_number == 4'd0 && prev_seq != seq_end)
                    r.sequence_error = 1'b1;
                prev_seq = it.sequence_number;
            end
            // Section and block order.
            want = prev_block[it.section_type] + 8'd1;
            case (it.section_type)
                SEC_HEADER: begin
                    r.block_error = (prev_section != SEC_VIDEO) || (it.block_number != 8'd0);
                end
                SEC_SUBCODE: begin
                    r.block_error = order_broken(it.block_number, SEC_HEADER, SEC_SUBCODE,
                                                 want, WRAP_SUBCODE);
                end
                SEC_VAUX: begin
                    r.block_error = order_broken(it.block_number, SEC_SUBCODE, SEC_VAUX,
                                                 want, WRAP_VAUX);
                end
                SEC_AUDIO: begin
                    r.block_error = order_broken(it.block_number, SEC_VAUX, SEC_VIDEO,
                                                 want, WRAP_AUDIO);
                end
                SEC_VIDEO: begin
                    r.block_error = !(prev_section == SEC_AUDIO || prev_section == SEC_VIDEO)
                        || (want != it.block_number
                            && !(want == WRAP_VIDEO && it.block_number == 8'd0));
                end
                default: begin
                end
            endcase
            prev_section = it.section_type;
            prev_block[it.section_type] = it.block_number;
            // Header blocks set the line system and count towards the limit.
            if (it.section_type == SEC_HEADER) begin
                sys_625   = it.system_625;
                sys_known = 1'b1;
                prev_seq  = it.system_625 ? SEQ_LAST_625 : SEQ_LAST_525;
                if (header_count != COUNT_MAX)
                    header_count++;
                if (header_count >= header_limit)
                    done = 1'b1;
            end
            r.checking_done = done;
            pending.push_back(r);
        endfunction

        // Compare one returned item with the oldest prediction.
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result item: seq_err=%0b blk_err=%0b done=%0b",
                             got.sequence_error, got.block_error, got.checking_done);
                return;
            end
            want = pending.pop_front();
            if (got.sequence_error !== want.sequence_error
                    || got.block_error !== want.block_error
                    || got.checking_done !== want.checking_done) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected seq_err=%0b blk_err=%0b done=%0b, got %0b %0b %0b",
                             want.sequence_error, want.block_error, want.checking_done,
                             got.sequence_error, got.block_error, got.checking_done);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    dif_order_scoreboard book;
    int   idle_cycles = 0;
    int   items_sent = 0;
    int   idle_pct = 0;
    bit   calm = 1'b0;
    int   stall_left = 0;
    logic [3:0] frame_seq = 4'd0;
    logic       frame_625 = 1'b0;
    logic [7:0] video_next = 8'd0;

    dv_dif_block_order_checker DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_data    (in_item),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_data   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge clk);
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Receiver: checks each returned item and stalls in random bursts.
    initial begin
        book = new;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                book.check_result(out_item);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(1, 100) <= idle_pct) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item dif_item(logic [2:0] sec, logic [3:0] seq,
                                          logic [7:0] blk, logic dsf);
        t_in_item it;
        it.section_type    = sec;
        it.sequence_number = seq;
        it.block_number    = blk;
        it.system_625      = dsf;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return dif_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Offer one item, with an occasional gap first, and wait for acceptance.
    task automatic send_item(input t_in_item it);
        if (!calm && $urandom_range(1, 100) <= idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
        book.note_block_header(it);
        items_sent++;
    endtask

    // Send an item of a well-formed sequence, now and then dropped or replaced.
    task automatic emit(input t_in_item it, input int noise_pct);
        if ($urandom_range(1, 100) <= noise_pct) begin
            if ($urandom_range(0, 1) == 0)
                send_item(random_item());
        end else begin
            send_item(it);
        end
    endtask

    // One DIF sequence: header, subcode, VAUX, then nine audio blocks each
    // followed by a run of video blocks whose numbers carry on across sequences.
    task automatic send_dif_sequence(input logic [3:0] seq, input logic dsf,
                                     input int per_audio, input int noise_pct);
        emit(dif_item(SEC_HEADER, seq, 8'd0, dsf), noise_pct);
        for (int b = 0; b < 2; b++)
            emit(dif_item(SEC_SUBCODE, seq, 8'(b), dsf), noise_pct);
        for (int b = 0; b < 3; b++)
            emit(dif_item(SEC_VAUX, seq, 8'(b), dsf), noise_pct);
        for (int a = 0; a < 9; a++) begin
            emit(dif_item(SEC_AUDIO, seq, 8'(a), dsf), noise_pct);
            for (int v = 0; v < per_audio; v++) begin
                emit(dif_item(SEC_VIDEO, seq, video_next, dsf), noise_pct);
                video_next = (video_next == WRAP_VIDEO - 8'd1) ? 8'd0 : video_next + 8'd1;
            end
        end
    endtask

    // Mostly well-formed sequences in frame order, with bursts of random items between.
    task automatic run_random(input int quota);
        int         stop_at;
        int         per_audio;
        int         noise;
        logic [3:0] seq_end;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(1, 10) <= 7) begin
                per_audio = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(1, 3);
                case ($urandom_range(0, 3))
                    0, 1: noise = 0;
                    2: noise = 2;
                    default: noise = 10;
                endcase
                send_dif_sequence(frame_seq, frame_625, per_audio, noise);
                seq_end = frame_625 ? SEQ_LAST_625 : SEQ_LAST_525;
                if (frame_seq == seq_end) begin
                    frame_seq = 4'd0;
                    if ($urandom_range(0, 9) == 0)
                        frame_625 = !frame_625;
                end else if ($urandom_range(0, 19) == 0) begin
                    // Frame cut short.
                    frame_seq = 4'd0;
                end else begin
                    frame_seq++;
                end
            end else begin
                repeat ($urandom_range(1, 20)) send_item(random_item());
            end
        end
    endtask

    // Hold the sender until every predicted item has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.header_limit = value;
    endtask

    // Main sequence of the run.
    initial begin
        int lo;
        wait (book != null);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_limit(COUNT_MAX);

        // Directed items: field extremes, every section and both systems.
        idle_pct = 20;
        send_item(dif_item(SEC_HEADER, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_SUBCODE, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_SUBCODE, 4'd0, 8'd1, 1'b0));
        send_item(dif_item(SEC_VAUX, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_VAUX, 4'd0, 8'd1, 1'b0));
        send_item(dif_item(SEC_VAUX, 4'd0, 8'd2, 1'b0));
        send_item(dif_item(SEC_AUDIO, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_VIDEO, 4'd0, 8'd0, 1'b1));
        send_item(dif_item(SEC_AUDIO, 4'd9, 8'd1, 1'b1));
        send_item(dif_item(SEC_VIDEO, 4'd9, 8'd1, 1'b0));
        send_item(dif_item(SEC_HEADER, 4'd0, 8'd0, 1'b1));
        send_item(dif_item(SEC_AUDIO, 4'd15, 8'd255, 1'b1));
        send_item(dif_item(SEC_VIDEO, 4'd0, 8'd255, 1'b0));
        send_item(dif_item(3'd5, 4'd7, 8'd255, 1'b1));
        send_item(dif_item(3'd6, 4'd3, 8'd0, 1'b0));
        send_item(dif_item(3'd7, 4'd11, 8'd128, 1'b1));
        send_item(dif_item(SEC_VIDEO, 4'd11, 8'd0, 1'b0));
        send_item(dif_item(SEC_HEADER, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_SUBCODE, 4'd15, 8'd2, 1'b1));
        send_item(dif_item(SEC_SUBCODE, 4'd0, 8'd0, 1'b0));
        send_item(dif_item(SEC_HEADER, 4'd5, 8'd255, 1'b1));
        send_item(dif_item(SEC_VIDEO, 4'd0, 8'd134, 1'b1));
        send_item(dif_item(SEC_VIDEO, 4'd0, 8'd0, 1'b1));

        // Random phases, each with its own header limit and idling rate.
        for (int p = 0; p < 4; p++) begin
            settle();
            lo = book.header_count + 60;
            write_limit((lo > 255) ? COUNT_MAX : 8'($urandom_range(lo, 255)));
            case (p)
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 40;
                default: idle_pct = 70;
            endcase
            run_random(240);
        end

        // Header flood that takes the header count up to one below full.
        settle();
        write_limit(COUNT_MAX);
        idle_pct = 15;
        while (book.header_count < COUNT_MAX - 8'd1)
            send_item(dif_item(SEC_HEADER, 4'($urandom_range(0, 15)),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0,
                               1'($urandom_range(0, 1))));

        // Last part without idling: a limit of 1 ends checking on a header
        // that carries errors of its own, and later items are ignored.
        settle();
        write_limit(8'd1);
        calm = 1'b1;
        idle_pct = 0;
        send_item(dif_item(SEC_SUBCODE, 4'd5, 8'd1, 1'b0));
        send_item(dif_item(SEC_HEADER, 4'd0, 8'd255, 1'b1));
        send_dif_sequence(frame_seq, frame_625, 1, 0);
        repeat (10) send_item(random_item());

        settle();
        repeat (4) @(posedge clk);
        if (book.failures == 0 && book.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
